@@ design/mmss_pkg.sv @@
// ----------------------------------------------------------------------------
// mmss_pkg
// Shared sizes, command codes and controller/datapath interface types for the
// middle snake search block.
// ----------------------------------------------------------------------------
package mmss_pkg;

    // store geometry
    localparam int MAX_LEN    = 256;
    localparam int TOKEN_BITS = 16;
    localparam int ADDR_W     = $clog2(MAX_LEN);
    localparam int CNT_W      = ADDR_W + 1;

    // diagonal vector geometry, addressed by diagonal relative to the center
    localparam int REACH_DEPTH = 1024;
    localparam int REACH_AW    = $clog2(REACH_DEPTH);
    localparam int COORD_W     = 12;

    typedef logic signed [COORD_W-1:0] coord_t;

    // input command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND1 = 2'd1;
    localparam logic [1:0] CMD_APPEND2 = 2'd2;
    localparam logic [1:0] CMD_RUN    = 2'd3;

    // datapath operations
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_INVALID  = 4'd1;
    localparam logic [3:0] OP_INIT     = 4'd2;
    localparam logic [3:0] OP_RD       = 4'd3;
    localparam logic [3:0] OP_SEL      = 4'd4;
    localparam logic [3:0] OP_TRD      = 4'd5;
    localparam logic [3:0] OP_STEP     = 4'd6;
    localparam logic [3:0] OP_WR       = 4'd7;
    localparam logic [3:0] OP_PASS_BWD = 4'd8;
    localparam logic [3:0] OP_NEXT_DD  = 4'd9;
    localparam logic [3:0] OP_FAIL     = 4'd10;

    typedef struct packed {
        logic       accept;
        logic [3:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic invalid;
        logic in_range;
        logic tok_eq;
        logic hit;
        logic last_diag;
        logic last_dd;
        logic fwd;
        logic out_busy;
    } dp_status_t;

endpackage

@@ design/myers_middle_snake_search_top.sv @@
// ----------------------------------------------------------------------------
// myers_middle_snake_search_top
// Token loader and bidirectional middle snake search engine.
// ----------------------------------------------------------------------------
// Clear and append transactions are accepted back to back. A run transaction
// holds off input until it finishes: a range check, then per diagonal visited
// a reach memory read, a move select and a write back, plus a token read state
// and a compare state per token compare of the snake follower, whose
// single-port token stores set the pace, and one more token read state
// when the snake stops at the edge of the range rather than on a mismatch.
// A pending state lies between each forward and reverse pass. A run of edit
// length D visits about (D/2+1)(D/2+2) diagonals. An invalid range is
// reported from the range check. The result sits in an output
// register; the range check of a new run waits until the previous result has
// been taken. No clearing pass is needed after reset.
module myers_middle_snake_search_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [15:0] token,
    input  logic [8:0]  first_lo,
    input  logic [8:0]  first_hi,
    input  logic [8:0]  second_lo,
    input  logic [8:0]  second_hi,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        status,
    output logic [9:0]  edit_length,
    output logic [8:0]  snake_first_start,
    output logic [8:0]  snake_second_start,
    output logic [8:0]  snake_steps
);

    mmss_pkg::dp_cmd_t    dcmd;
    mmss_pkg::dp_status_t st;

    // sequencer
    mmss_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .in_ready (in_ready),
        .st       (st),
        .dcmd     (dcmd)
    );

    // datapath
    mmss_dp u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .dcmd               (dcmd),
        .cmd                (cmd),
        .token              (token),
        .first_lo           (first_lo),
        .first_hi           (first_hi),
        .second_lo          (second_lo),
        .second_hi          (second_hi),
        .st                 (st),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .edit_length        (edit_length),
        .snake_first_start  (snake_first_start),
        .snake_second_start (snake_second_start),
        .snake_steps        (snake_steps)
    );

endmodule

@@ design/mmss_ctrl.sv @@
// ----------------------------------------------------------------------------
// mmss_ctrl
// Sequencer for the search: walks diagonals of each forward and reverse pass
// and steps the snake follower one token compare at a time.
// ----------------------------------------------------------------------------
module mmss_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           cmd,
    output logic                 in_ready,
    input  mmss_pkg::dp_status_t st,
    output mmss_pkg::dp_cmd_t    dcmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_SEL   = 3'd3;
    localparam logic [2:0] S_TRD   = 3'd4;
    localparam logic [2:0] S_TCMP  = 3'd5;
    localparam logic [2:0] S_WR    = 3'd6;
    localparam logic [2:0] S_PEND  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and datapath operation
    always_comb
    begin
        state_next  = state_reg;
        dcmd.accept = in_valid && in_ready;
        dcmd.op     = mmss_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && cmd == mmss_pkg::CMD_RUN)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!st.out_busy)
                begin
                    if (st.invalid)
                    begin
                        dcmd.op    = mmss_pkg::OP_INVALID;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        dcmd.op    = mmss_pkg::OP_INIT;
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                dcmd.op    = mmss_pkg::OP_RD;
                state_next = S_SEL;
            end
            S_SEL:
            begin
                dcmd.op    = mmss_pkg::OP_SEL;
                state_next = S_TRD;
            end
            S_TRD:
            begin
                if (st.in_range)
                begin
                    dcmd.op    = mmss_pkg::OP_TRD;
                    state_next = S_TCMP;
                end
                else
                    state_next = S_WR;
            end
            S_TCMP:
            begin
                if (st.tok_eq)
                begin
                    dcmd.op    = mmss_pkg::OP_STEP;
                    state_next = S_TRD;
                end
                else
                    state_next = S_WR;
            end
            S_WR:
            begin
                dcmd.op = mmss_pkg::OP_WR;
                if (st.hit)
                    state_next = S_IDLE;
                else if (st.last_diag)
                    state_next = S_PEND;
                else
                    state_next = S_RD;
            end
            S_PEND:
            begin
                if (st.fwd)
                begin
                    dcmd.op    = mmss_pkg::OP_PASS_BWD;
                    state_next = S_RD;
                end
                else if (st.last_dd)
                begin
                    dcmd.op    = mmss_pkg::OP_FAIL;
                    state_next = S_IDLE;
                end
                else
                begin
                    dcmd.op    = mmss_pkg::OP_NEXT_DD;
                    state_next = S_RD;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ design/mmss_dp.sv @@
// ----------------------------------------------------------------------------
// mmss_dp
// Token stores, forward and reverse reach memories, diagonal and snake
// registers, and the result register.
// ----------------------------------------------------------------------------
module mmss_dp
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mmss_pkg::dp_cmd_t    dcmd,
    input  logic [1:0]           cmd,
    input  logic [15:0]          token,
    input  logic [8:0]           first_lo,
    input  logic [8:0]           first_hi,
    input  logic [8:0]           second_lo,
    input  logic [8:0]           second_hi,
    output mmss_pkg::dp_status_t st,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 status,
    output logic [9:0]           edit_length,
    output logic [8:0]           snake_first_start,
    output logic [8:0]           snake_second_start,
    output logic [8:0]           snake_steps
);

    logic [mmss_pkg::TOKEN_BITS-1:0] first_mem  [mmss_pkg::MAX_LEN];
    logic [mmss_pkg::TOKEN_BITS-1:0] second_mem [mmss_pkg::MAX_LEN];
    mmss_pkg::coord_t fr_mem [mmss_pkg::REACH_DEPTH];
    mmss_pkg::coord_t br_mem [mmss_pkg::REACH_DEPTH];

    logic [mmss_pkg::CNT_W-1:0]      fcnt_reg, scnt_reg;
    logic [8:0]                      flo_reg, fhi_reg, slo_reg, shi_reg;
    logic [mmss_pkg::TOKEN_BITS-1:0] ftok_q, stok_q;
    mmss_pkg::coord_t                fr_q, br_q;
    mmss_pkg::coord_t                k_reg, x_reg, y_reg, prev_reg;
    logic [8:0]                      dd_reg, len_reg;
    logic                            fwd_reg;
    logic                            out_valid_reg;
    logic                            status_reg;
    logic [9:0]                      edit_reg;
    logic [8:0]                      sfs_reg, sss_reg, slen_reg;

    mmss_pkg::coord_t flo_c, fhi_c, slo_c, shi_c, n_c, m_c, delta, ddc;
    mmss_pkg::coord_t kl, kh, nbr, chk, x_sel, rel;
    logic [9:0]       total;
    logic [10:0]      half_sum;
    logic             odd, use_up;
    logic [mmss_pkg::REACH_AW-1:0] ka, ka1;
    logic [mmss_pkg::ADDR_W-1:0]   fa, sa;

    // run geometry from the latched ranges
    assign flo_c    = mmss_pkg::coord_t'({3'b0, flo_reg});
    assign fhi_c    = mmss_pkg::coord_t'({3'b0, fhi_reg});
    assign slo_c    = mmss_pkg::coord_t'({3'b0, slo_reg});
    assign shi_c    = mmss_pkg::coord_t'({3'b0, shi_reg});
    assign n_c      = fhi_c - flo_c;
    assign m_c      = shi_c - slo_c;
    assign delta    = n_c - m_c;
    assign total    = 10'(n_c + m_c);
    assign odd      = total[0];
    assign half_sum = 11'({1'b0, total} + 11'd1);
    assign ddc      = mmss_pkg::coord_t'({3'b0, dd_reg});
    assign kl       = fwd_reg ? -ddc : delta - ddc;
    assign kh       = fwd_reg ? ddc : delta + ddc;

    // diagonal addresses, centered in the reach memories
    assign ka  = {~k_reg[mmss_pkg::REACH_AW-1], k_reg[mmss_pkg::REACH_AW-2:0]};
    assign ka1 = ka + 1'b1;

    // neighbor reach on the upper diagonal and the opposite vector at this one
    always_comb
    begin
        if (dd_reg == 9'd0)
            nbr = fwd_reg ? '0 : n_c + mmss_pkg::coord_t'(1);
        else
            nbr = fwd_reg ? fr_q : br_q;
        chk = fwd_reg ? br_q : fr_q;
    end

    // choice of the move into this diagonal
    always_comb
    begin
        if (fwd_reg)
        begin
            use_up = (k_reg == kl) || (k_reg != kh && prev_reg < nbr);
            x_sel  = use_up ? nbr : prev_reg + mmss_pkg::coord_t'(1);
        end
        else
        begin
            use_up = (k_reg == kl) || (k_reg != kh && nbr <= prev_reg);
            x_sel  = use_up ? nbr - mmss_pkg::coord_t'(1) : prev_reg;
        end
    end

    assign rel = x_reg - flo_c;

    // token addresses for the snake compare
    assign fa = fwd_reg ? x_reg[mmss_pkg::ADDR_W-1:0] : x_reg[mmss_pkg::ADDR_W-1:0] - 1'b1;
    assign sa = fwd_reg ? y_reg[mmss_pkg::ADDR_W-1:0] : y_reg[mmss_pkg::ADDR_W-1:0] - 1'b1;

    // status to the sequencer
    always_comb
    begin
        st.invalid  = (flo_reg > fhi_reg) || (slo_reg > shi_reg) ||
                      (fhi_reg > fcnt_reg) || (shi_reg > scnt_reg);
        if (fwd_reg)
            st.in_range = x_reg >= flo_c && x_reg < fhi_c && y_reg >= slo_c && y_reg < shi_c;
        else
            st.in_range = x_reg > flo_c && x_reg <= fhi_c && y_reg > slo_c && y_reg <= shi_c;
        st.tok_eq   = (ftok_q == stok_q);
        if (fwd_reg)
            st.hit = odd && k_reg >= delta - ddc + 1 && k_reg <= delta + ddc - 1 && rel >= chk;
        else
            st.hit = !odd && k_reg >= -ddc && k_reg <= ddc && chk >= rel;
        st.last_diag = (k_reg == kh);
        st.last_dd   = ({2'b0, dd_reg} == (half_sum >> 1));
        st.fwd       = fwd_reg;
        st.out_busy  = out_valid_reg;
    end

    // token stores
    always_ff @(posedge clk)
    begin
        if (dcmd.accept && cmd == mmss_pkg::CMD_APPEND1 && fcnt_reg < mmss_pkg::MAX_LEN)
            first_mem[fcnt_reg[mmss_pkg::ADDR_W-1:0]] <= token[mmss_pkg::TOKEN_BITS-1:0];
        if (dcmd.accept && cmd == mmss_pkg::CMD_APPEND2 && scnt_reg < mmss_pkg::MAX_LEN)
            second_mem[scnt_reg[mmss_pkg::ADDR_W-1:0]] <= token[mmss_pkg::TOKEN_BITS-1:0];
        if (dcmd.op == mmss_pkg::OP_TRD)
        begin
            ftok_q <= first_mem[fa];
            stok_q <= second_mem[sa];
        end
    end

    // reach memories
    always_ff @(posedge clk)
    begin
        if (dcmd.op == mmss_pkg::OP_RD)
        begin
            fr_q <= fwd_reg ? fr_mem[ka1] : fr_mem[ka];
            br_q <= fwd_reg ? br_mem[ka] : br_mem[ka1];
        end
        if (dcmd.op == mmss_pkg::OP_WR)
        begin
            if (fwd_reg)
                fr_mem[ka] <= rel;
            else
                br_mem[ka] <= rel;
        end
    end

    // range latch and walk registers
    always_ff @(posedge clk)
    begin
        if (dcmd.accept && cmd == mmss_pkg::CMD_RUN)
        begin
            flo_reg <= first_lo;
            fhi_reg <= first_hi;
            slo_reg <= second_lo;
            shi_reg <= second_hi;
        end
        case (dcmd.op)
            mmss_pkg::OP_INIT:
            begin
                dd_reg  <= '0;
                fwd_reg <= 1'b1;
                k_reg   <= '0;
            end
            mmss_pkg::OP_SEL:
            begin
                x_reg   <= x_sel + flo_c;
                y_reg   <= x_sel - k_reg + slo_c;
                len_reg <= '0;
            end
            mmss_pkg::OP_STEP:
            begin
                x_reg   <= fwd_reg ? x_reg + mmss_pkg::coord_t'(1)
                                   : x_reg - mmss_pkg::coord_t'(1);
                y_reg   <= fwd_reg ? y_reg + mmss_pkg::coord_t'(1)
                                   : y_reg - mmss_pkg::coord_t'(1);
                len_reg <= len_reg + 1'b1;
            end
            mmss_pkg::OP_WR:
            begin
                prev_reg <= nbr;
                k_reg    <= k_reg + mmss_pkg::coord_t'(2);
            end
            mmss_pkg::OP_PASS_BWD:
            begin
                fwd_reg <= 1'b0;
                k_reg   <= delta - ddc;
            end
            mmss_pkg::OP_NEXT_DD:
            begin
                dd_reg  <= dd_reg + 1'b1;
                fwd_reg <= 1'b1;
                k_reg   <= -(ddc + mmss_pkg::coord_t'(1));
            end
            default:
            begin
            end
        endcase
    end

    // load counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcnt_reg <= '0;
            scnt_reg <= '0;
        end
        else if (dcmd.accept)
        begin
            if (cmd == mmss_pkg::CMD_CLEAR)
            begin
                fcnt_reg <= '0;
                scnt_reg <= '0;
            end
            else if (cmd == mmss_pkg::CMD_APPEND1 && fcnt_reg < mmss_pkg::MAX_LEN)
                fcnt_reg <= fcnt_reg + 1'b1;
            else if (cmd == mmss_pkg::CMD_APPEND2 && scnt_reg < mmss_pkg::MAX_LEN)
                scnt_reg <= scnt_reg + 1'b1;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (dcmd.op == mmss_pkg::OP_INVALID)
        begin
            status_reg <= 1'b1;
            edit_reg   <= '0;
            sfs_reg    <= '0;
            sss_reg    <= '0;
            slen_reg   <= '0;
        end
        else if (dcmd.op == mmss_pkg::OP_FAIL)
        begin
            status_reg <= 1'b0;
            edit_reg   <= total;
            sfs_reg    <= '0;
            sss_reg    <= '0;
            slen_reg   <= '0;
        end
        else if (dcmd.op == mmss_pkg::OP_WR && st.hit)
        begin
            status_reg <= 1'b0;
            slen_reg   <= len_reg;
            if (fwd_reg)
            begin
                edit_reg <= {dd_reg, 1'b0} - 10'd1;
                sfs_reg  <= 9'(x_reg - mmss_pkg::coord_t'({3'b0, len_reg}));
                sss_reg  <= 9'(y_reg - mmss_pkg::coord_t'({3'b0, len_reg}));
            end
            else
            begin
                edit_reg <= {dd_reg, 1'b0};
                sfs_reg  <= 9'(x_reg);
                sss_reg  <= 9'(y_reg);
            end
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (dcmd.op == mmss_pkg::OP_INVALID || dcmd.op == mmss_pkg::OP_FAIL ||
                 (dcmd.op == mmss_pkg::OP_WR && st.hit))
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid          = out_valid_reg;
    assign status             = status_reg;
    assign edit_length        = edit_reg;
    assign snake_first_start  = sfs_reg;
    assign snake_second_start = sss_reg;
    assign snake_steps        = slen_reg;

endmodule

@@ tb/sv/tb_myers_middle_snake_search_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_myers_middle_snake_search_top
// Loads token sequences and runs middle snake searches over random and
// corner-case subranges, comparing each result with a local prediction of
// the bidirectional search under several sender and receiver idling phases.
// ----------------------------------------------------------------------------
module tb_myers_middle_snake_search_top;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DIAG_SPAN   = 4 * mmss_pkg::MAX_LEN + 8;

    typedef struct {
        logic       status;
        logic [9:0] edit_length;
        logic [8:0] snake_first_start;
        logic [8:0] snake_second_start;
        logic [8:0] snake_steps;
    } snake_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [15:0] token;
    logic [8:0]  first_lo;
    logic [8:0]  first_hi;
    logic [8:0]  second_lo;
    logic [8:0]  second_hi;
    logic        out_valid;
    logic        out_ready;
    logic        status;
    logic [9:0]  edit_length;
    logic [8:0]  snake_first_start;
    logic [8:0]  snake_second_start;
    logic [8:0]  snake_steps;

    // predictor state
    logic [15:0] seq_a [mmss_pkg::MAX_LEN];
    logic [15:0] seq_b [mmss_pkg::MAX_LEN];
    int          count_a;
    int          count_b;
    int          fwd_reach [DIAG_SPAN];
    int          bwd_reach [DIAG_SPAN];

    snake_result_t expected_results [$];

    int  error_count;
    int  cycle_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_off_cycles;
    int  runs_sent;
    int  results_seen;

    myers_middle_snake_search_top dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .cmd                (cmd),
        .token              (token),
        .first_lo           (first_lo),
        .first_hi           (first_hi),
        .second_lo          (second_lo),
        .second_hi          (second_hi),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .edit_length        (edit_length),
        .snake_first_start  (snake_first_start),
        .snake_second_start (snake_second_start),
        .snake_steps        (snake_steps)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("myers_middle_snake_search_top test failed");
            $finish;
        end
    end

    function automatic int reach_at(input int which, input int idx);
        if (idx < 0 || idx >= DIAG_SPAN)
            return 0;
        return (which == 0) ? fwd_reach[idx] : bwd_reach[idx];
    endfunction

    function automatic void reach_set(input int which, input int idx, input int val);
        if (idx >= 0 && idx < DIAG_SPAN)
        begin
            if (which == 0)
                fwd_reach[idx] = val;
            else
                bwd_reach[idx] = val;
        end
    endfunction

    function automatic bit tokens_match(input int a, input int b);
        if (a < 0 || a >= mmss_pkg::MAX_LEN || b < 0 || b >= mmss_pkg::MAX_LEN)
            return 1'b0;
        return seq_a[a] == seq_b[b];
    endfunction

    // bidirectional search over [flo,fhi) x [slo,shi)
    function automatic snake_result_t search_middle_snake(input int flo, input int fhi,
                                                          input int slo, input int shi);
        snake_result_t r;
        int n, m, total, delta, offset, dd, d, lo, hi, x, y, len, k;
        bit odd;
        n = fhi - flo;
        m = shi - slo;
        total = n + m;
        delta = n - m;
        offset = total + 1 + (delta < 0 ? -delta : delta);
        odd = total[0];
        r = '{1'b0, 10'(total), 9'd0, 9'd0, 9'd0};
        for (int i = 0; i < DIAG_SPAN; i++)
        begin
            fwd_reach[i] = 0;
            bwd_reach[i] = n + 1;
        end
        for (dd = 0; dd <= (total + 1) / 2; dd++)
        begin
            lo = offset - dd;
            hi = offset + dd;
            for (d = lo; d <= hi; d += 2)
            begin
                len = 0;
                if (d == lo || (d != hi && reach_at(0, d - 1) < reach_at(0, d + 1)))
                    x = reach_at(0, d + 1);
                else
                    x = reach_at(0, d - 1) + 1;
                y = x + offset - d + slo;
                x += flo;
                while (x >= flo && x < fhi && y >= slo && y < shi && tokens_match(x, y))
                begin
                    x++; y++; len++;
                end
                reach_set(0, d, x - flo);
                k = d - offset;
                if (odd && k >= delta - dd + 1 && k <= delta + dd - 1 &&
                    reach_at(0, d) >= reach_at(1, d))
                    return '{1'b0, 10'(dd * 2 - 1), 9'(x - len), 9'(y - len), 9'(len)};
            end
            lo += delta;
            hi += delta;
            for (d = lo; d <= hi; d += 2)
            begin
                len = 0;
                if (d == lo || (d != hi && reach_at(1, d + 1) <= reach_at(1, d - 1)))
                    x = reach_at(1, d + 1) - 1;
                else
                    x = reach_at(1, d - 1);
                y = x + offset - d + slo;
                x += flo;
                while (x > flo && x <= fhi && y > slo && y <= shi &&
                       tokens_match(x - 1, y - 1))
                begin
                    x--; y--; len++;
                end
                reach_set(1, d, x - flo);
                k = d - offset;
                if (!odd && k >= -dd && k <= dd && reach_at(0, d) >= reach_at(1, d))
                    return '{1'b0, 10'(dd * 2), 9'(x), 9'(y), 9'(len)};
            end
        end
        return r;
    endfunction

    // predictor for one accepted transaction
    function automatic void predict_transaction(input logic [1:0] c, input logic [15:0] t,
                                                input int flo, input int fhi,
                                                input int slo, input int shi);
        case (c)
            mmss_pkg::CMD_CLEAR:
            begin
                count_a = 0;
                count_b = 0;
            end
            mmss_pkg::CMD_APPEND1:
                if (count_a < mmss_pkg::MAX_LEN)
                begin
                    seq_a[count_a] = t;
                    count_a++;
                end
            mmss_pkg::CMD_APPEND2:
                if (count_b < mmss_pkg::MAX_LEN)
                begin
                    seq_b[count_b] = t;
                    count_b++;
                end
            default:
                if (flo > fhi || slo > shi || fhi > count_a || shi > count_b)
                    expected_results.insert(expected_results.size(),
                                            '{1'b1, 10'd0, 9'd0, 9'd0, 9'd0});
                else
                    expected_results.insert(expected_results.size(),
                                            search_middle_snake(flo, fhi, slo, shi));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    // send one transaction
    task automatic send_transaction(input logic [1:0] c, input logic [15:0] t,
                                    input int flo, input int fhi,
                                    input int slo, input int shi);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        token     <= t;
        first_lo  <= 9'(flo);
        first_hi  <= 9'(fhi);
        second_lo <= 9'(slo);
        second_hi <= 9'(shi);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_transaction(c, t, flo, fhi, slo, shi);
        if (c == mmss_pkg::CMD_RUN)
            runs_sent++;
    endtask

    task automatic send_run(input int flo, input int fhi, input int slo, input int shi);
        send_transaction(mmss_pkg::CMD_RUN, 16'($urandom), flo, fhi, slo, shi);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // receiver ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        snake_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report_mismatch("unexpected result transaction", 1, 0);
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (edit_length !== want.edit_length)
                    report_mismatch("edit_length", edit_length, want.edit_length);
                if (snake_first_start !== want.snake_first_start)
                    report_mismatch("snake_first_start", snake_first_start,
                                    want.snake_first_start);
                if (snake_second_start !== want.snake_second_start)
                    report_mismatch("snake_second_start", snake_second_start,
                                    want.snake_second_start);
                if (snake_steps !== want.snake_steps)
                    report_mismatch("snake_steps", snake_steps, want.snake_steps);
            end
        end
    end

    // load a random pair of sequences from a small alphabet so snakes occur
    task automatic load_pair(input int len_a, input int len_b, input int alphabet);
        send_transaction(mmss_pkg::CMD_CLEAR, 16'($urandom), $urandom_range(511),
                         $urandom_range(511), $urandom_range(511), $urandom_range(511));
        for (int i = 0; i < len_a; i++)
            send_transaction(mmss_pkg::CMD_APPEND1, 16'($urandom_range(alphabet - 1)),
                             0, 0, 0, 0);
        for (int i = 0; i < len_b; i++)
            send_transaction(mmss_pkg::CMD_APPEND2, 16'($urandom_range(alphabet - 1)),
                             0, 0, 0, 0);
    endtask

    task automatic test_directed();
        // empty ranges and invalid ranges on empty stores
        send_transaction(mmss_pkg::CMD_CLEAR, 16'hFFFF, 0, 0, 0, 0);
        send_run(0, 0, 0, 0);
        send_run(0, 1, 0, 0);
        send_run(1, 0, 0, 0);
        // extreme token values
        send_transaction(mmss_pkg::CMD_APPEND1, 16'hFFFF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF);
        send_transaction(mmss_pkg::CMD_APPEND1, 16'h0000, 0, 0, 0, 0);
        send_transaction(mmss_pkg::CMD_APPEND2, 16'hFFFF, 0, 0, 0, 0);
        send_transaction(mmss_pkg::CMD_APPEND2, 16'h5555, 0, 0, 0, 0);
        send_transaction(mmss_pkg::CMD_APPEND2, 16'hAAAA, 0, 0, 0, 0);
        send_run(0, 2, 0, 3);
        send_run(1, 1, 2, 2);
        send_run(0, 2, 0, 4);
        send_run(0, 2, 2, 1);
        send_run(2, 2, 0, 3);
        send_run(511, 511, 511, 511);
        send_run(0, 0, 1, 3);
        // full stores with nearly identical content, differing at every 40th token; appends past full
        send_transaction(mmss_pkg::CMD_CLEAR, 0, 0, 0, 0, 0);
        for (int i = 0; i < mmss_pkg::MAX_LEN + 2; i++)
            send_transaction(mmss_pkg::CMD_APPEND1, 16'(i * 7), 0, 0, 0, 0);
        for (int i = 0; i < mmss_pkg::MAX_LEN + 2; i++)
            send_transaction(mmss_pkg::CMD_APPEND2, 16'(i * 7 + ((i % 40) == 3)),
                             0, 0, 0, 0);
        send_run(0, mmss_pkg::MAX_LEN, 0, mmss_pkg::MAX_LEN);
        send_run(0, mmss_pkg::MAX_LEN, 0, mmss_pkg::MAX_LEN + 1);
        send_run(100, 140, 120, 150);
        wait_drain();
    endtask

    task automatic test_random(input int n_runs, input int max_len);
        int la, lb, flo, fhi, slo, shi;
        for (int r = 0; r < n_runs; r++)
        begin
            if (r % 4 == 0)
            begin
                la = $urandom_range(max_len);
                lb = $urandom_range(max_len);
                load_pair(la, lb, $urandom_range(1, 4));
            end
            flo = $urandom_range(count_a);
            fhi = $urandom_range(flo, count_a);
            slo = $urandom_range(count_b);
            shi = $urandom_range(slo, count_b);
            // occasional broken range or random noise
            if ($urandom_range(9) == 0)
            begin
                flo = $urandom_range(511);
                fhi = $urandom_range(511);
                slo = $urandom_range(511);
                shi = $urandom_range(511);
            end
            send_run(flo, fhi, slo, shi);
        end
    endtask

    task automatic test_backpressure();
        load_pair(6, 6, 2);
        hold_off_cycles = 400;
        for (int i = 0; i < 6; i++)
            send_run(0, $urandom_range(6), 0, $urandom_range(6));
        wait_drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = mmss_pkg::CMD_CLEAR;
        token = '0;
        first_lo = '0;
        first_hi = '0;
        second_lo = '0;
        second_hi = '0;
        count_a = 0;
        count_b = 0;
        error_count = 0;
        cycle_count = 0;
        hold_off_cycles = 0;
        runs_sent = 0;
        results_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(120, 12);
        send_idle_pct = 68;
        test_random(30, 12);
        wait_drain();
        send_idle_pct = 0;
        recv_stall_pct = 68;
        test_random(30, 12);
        send_idle_pct = 21;
        recv_stall_pct = 21;
        test_random(60, 24);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        test_random(6, 64);

        wait_drain();
        repeat (20) @(posedge clk);
        $display("covered %0d search runs with %0d results checked, including full stores,",
                 runs_sent, results_seen);
        $display("invalid and empty ranges, and long receiver hold-off");
        if (error_count == 0)
            $display("myers_middle_snake_search_top test passed");
        else
            $display("myers_middle_snake_search_top test failed");
        $finish;
    end

endmodule
